[sv/urpd_pkg.sv]
// ----------------------------------------------------------------------------
// urpd_pkg
// Shared types, constants and the ramp curve math for the two-zone
// ultrasonic ranger / vibration motor controller.
// ----------------------------------------------------------------------------
package urpd_pkg;

  // Ramp shape
  localparam int NEAR_FULL_MM      = 20;
  localparam int FAR_OFF_MM        = 2000;
  localparam int DUTY_FLOOR        = 40;
  localparam int CURVE_TABLE_DEPTH = 2048;

  // Register reset values
  localparam logic [15:0] ECHO_TIMEOUT_RST = 16'd25000;
  localparam logic [15:0] PING_GAP_RST     = 16'd20000;
  localparam logic [15:0] PWM_PERIOD_RST   = 16'd5000;

  // Trigger timing in ticks
  localparam logic [3:0] TRIG_LOW_TICKS  = 4'd2;
  localparam logic [3:0] TRIG_HIGH_TICKS = 4'd10;

  // mm = width*343/2000 as (width*DIST_RECIP) >> DIST_SHIFT, exact for 16-bit widths
  localparam int          DIST_SHIFT = 27;
  localparam logic [24:0] DIST_RECIP = 25'd23018341;
  localparam logic [12:0] DIST_MAX   = 13'd4287;

  typedef logic [13:0] dist_t;
  localparam dist_t DIST_NO_ECHO = 14'h3FFF;

  typedef enum logic [2:0] {
    PH_TRIG_LOW  = 3'd0,
    PH_TRIG_HIGH = 3'd1,
    PH_WAIT_IDLE = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_MEASURE   = 3'd4,
    PH_GAP       = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    REG_ECHO_TIMEOUT = 2'd0,
    REG_PING_GAP     = 2'd1,
    REG_PWM_PERIOD   = 2'd2
  } reg_idx_t;

  localparam logic [63:0] ONE_Q24 = 64'd1 << 24;

  // ceil(2^32/k): Taylor terms stay below 2^25, so (t * INV_K[k]) >> 32 is floor(t/k)
  localparam logic [63:0] INV_K [1:8] = '{
    64'd4294967296, 64'd2147483648, 64'd1431655766, 64'd1073741824,
    64'd858993460,  64'd715827883,  64'd613566757,  64'd536870912
  };

  // exp(x) in Q24: Taylor series on x/16, then squared four times
  function automatic logic [63:0] exp_q24(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] sum;
    r    = x >> 4;
    term = ONE_Q24;
    sum  = ONE_Q24;
    for (int k = 1; k <= 8; k++) begin
      term = (((term * r) >> 24) * INV_K[k]) >> 32;
      sum  = sum + term;
    end
    for (int i = 0; i < 4; i++) begin
      sum = (sum * sum) >> 24;
    end
    return sum;
  endfunction

  // ramp divisors as reciprocals, wide enough to give exact floors
  localparam int           RAMP_SPAN  = (FAR_OFF_MM > NEAR_FULL_MM) ?
                                        FAR_OFF_MM - NEAR_FULL_MM : 1;
  localparam int           SPAN_SHIFT = 50;
  localparam logic [127:0] SPAN_RECIP = ((128'd1 << SPAN_SHIFT) + 128'(RAMP_SPAN) - 128'd1) /
                                        128'(RAMP_SPAN);
  localparam logic [63:0]  RAMP_DEN   = exp_q24(64'd4 << 24) - ONE_Q24;
  localparam int           DEN_SHIFT  = 68;
  localparam logic [127:0] DEN_RECIP  = ((128'd1 << DEN_SHIFT) + 128'(RAMP_DEN) - 128'd1) /
                                        128'(RAMP_DEN);

  function automatic logic [7:0] ramp_duty(input int mm);
    logic [63:0]  x;
    logic [63:0]  num;
    logic [63:0]  d;
    logic [127:0] wide;
    if (mm < 0 || mm > FAR_OFF_MM) begin
      return 8'd0;
    end
    if (mm <= NEAR_FULL_MM) begin
      return 8'd255;
    end
    wide = (128'(FAR_OFF_MM - mm) << 26) * SPAN_RECIP;
    x    = 64'(wide >> SPAN_SHIFT);
    num  = exp_q24(x) - ONE_Q24;
    wide = 128'(num * 64'(255 - DUTY_FLOOR)) * DEN_RECIP;
    d    = 64'(DUTY_FLOOR) + 64'(wide >> DEN_SHIFT);
    return (d > 64'd255) ? 8'd255 : d[7:0];
  endfunction

endpackage

[sv/ultrasonic_range_to_pwm_duty_top.sv]
// ----------------------------------------------------------------------------
// ultrasonic_range_to_pwm_duty_top
// Alternating two-zone ultrasonic ping/echo timer; echo width becomes a
// distance, the distance a motor duty through a ramp ROM, the duty 256-step PWM.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+----------------------
//  in      | echo_a, echo_b                            | in_valid / in_stall
//  out     | trig_a/b, motor_a/b, report_*             | out_valid / out_stall
//  cfg     | cfg_index, cfg_data                       | cfg_valid / cfg_ready
//
//  One tick item per clock; the ping state
//  machine and distance multiply run in the first stage, the registered
//  curve ROM read and PWM compares in the second.
//  A stalled output freezes both stages and holds off input.
//  Reset is synchronous; no init sweep, the curve ROM is constant.
// ----------------------------------------------------------------------------
module ultrasonic_range_to_pwm_duty_top #(
  parameter int CURVE_TABLE_DEPTH = urpd_pkg::CURVE_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               echo_a,
  input  logic               echo_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               trig_a,
  output logic               trig_b,
  output logic               motor_a,
  output logic               motor_b,
  output logic               report_valid,
  output logic               report_zone,
  output logic signed [13:0] report_distance_mm,
  output logic        [7:0]  report_duty,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [1:0]  cfg_index,
  input  logic        [15:0] cfg_data
);

  localparam int AW = $clog2(CURVE_TABLE_DEPTH);

  typedef logic [7:0] curve_t [CURVE_TABLE_DEPTH];

  function automatic curve_t build_curve();
    curve_t c;
    for (int i = 0; i < CURVE_TABLE_DEPTH; i++) begin
      c[i] = urpd_pkg::ramp_duty(i);
    end
    return c;
  endfunction

  localparam curve_t CURVE = build_curve();

  // config registers
  logic [15:0] echo_timeout;
  logic [15:0] ping_gap;
  logic [15:0] pwm_period;

  // ping state
  logic             active_zone, active_zone_next;
  urpd_pkg::phase_t ping_phase, ping_phase_next;
  logic [15:0]      phase_ticks, phase_ticks_next;
  logic [15:0]      echo_width, echo_width_next;
  logic [15:0]      pwm_count, pwm_count_next;
  logic [7:0]       zone_duty [2];

  // stage 1
  logic            s1_valid;
  logic            s1_trig_a;
  logic            s1_trig_b;
  logic            s1_done;
  logic            s1_zone;
  urpd_pkg::dist_t s1_mm;
  logic            s1_lut_zero;
  logic [15:0]     s1_pwm_pos;
  logic [15:0]     s1_period;
  logic [7:0]      rom_q;

  // first stage combinational
  logic            adv;
  logic            accept;
  logic            echo;
  logic            trig;
  logic [40:0]     width_prod;
  logic [13:0]     dist_raw;
  logic [12:0]     dist_mm;
  logic [16:0]     ticks_inc;
  logic [16:0]     cnt_inc;
  logic            in_ping;
  logic            fell;
  logic            timed_out;
  logic            done;
  urpd_pkg::dist_t mm_val;
  logic            lut_zero;
  logic [AW-1:0]   rom_addr;

  // second stage combinational
  logic [7:0]      duty;
  logic [23:0]     thr_a;
  logic [23:0]     thr_b;
  logic [23:0]     pwm_pos;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign accept    = in_valid && adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_timeout <= urpd_pkg::ECHO_TIMEOUT_RST;
      ping_gap     <= urpd_pkg::PING_GAP_RST;
      pwm_period   <= urpd_pkg::PWM_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (urpd_pkg::reg_idx_t'(cfg_index))
        urpd_pkg::REG_ECHO_TIMEOUT: echo_timeout <= cfg_data;
        urpd_pkg::REG_PING_GAP:     ping_gap     <= cfg_data;
        urpd_pkg::REG_PWM_PERIOD:   pwm_period   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- ping FSM outputs ----------------
  always_comb begin
    echo       = active_zone ? echo_b : echo_a;
    trig       = (ping_phase == urpd_pkg::PH_TRIG_HIGH);
    width_prod = 41'(echo_width) * 41'(urpd_pkg::DIST_RECIP);
    dist_raw   = width_prod[urpd_pkg::DIST_SHIFT +: 14];
    dist_mm    = (dist_raw > {1'b0, urpd_pkg::DIST_MAX}) ? urpd_pkg::DIST_MAX
                                                         : dist_raw[12:0];
    ticks_inc  = {1'b0, phase_ticks} + 17'd1;
    cnt_inc    = {1'b0, pwm_count} + 17'd1;
    in_ping    = ping_phase inside {urpd_pkg::PH_WAIT_IDLE, urpd_pkg::PH_WAIT_RISE,
                                    urpd_pkg::PH_MEASURE};
    fell       = (ping_phase == urpd_pkg::PH_MEASURE) && !echo;
    timed_out  = in_ping && !fell && (ticks_inc >= {1'b0, echo_timeout});
    done       = fell || timed_out;
    mm_val     = timed_out ? urpd_pkg::DIST_NO_ECHO : {1'b0, dist_mm};
    lut_zero   = timed_out || (32'(dist_mm) > urpd_pkg::FAR_OFF_MM);
    if (32'(dist_mm) >= CURVE_TABLE_DEPTH) begin
      rom_addr = AW'(CURVE_TABLE_DEPTH - 1);
    end else begin
      rom_addr = dist_mm[AW-1:0];
    end
  end

  // ---------------- ping FSM next state ----------------
  always_comb begin
    active_zone_next = active_zone;
    ping_phase_next  = ping_phase;
    phase_ticks_next = phase_ticks;
    echo_width_next  = echo_width;
    pwm_count_next   = (cnt_inc >= {1'b0, pwm_period}) ? 16'd0 : cnt_inc[15:0];

    case (ping_phase)
      urpd_pkg::PH_TRIG_LOW: begin
        if (ticks_inc >= 17'(urpd_pkg::TRIG_LOW_TICKS)) begin
          ping_phase_next  = urpd_pkg::PH_TRIG_HIGH;
          phase_ticks_next = '0;
        end else begin
          phase_ticks_next = ticks_inc[15:0];
        end
      end
      urpd_pkg::PH_TRIG_HIGH: begin
        if (ticks_inc >= 17'(urpd_pkg::TRIG_HIGH_TICKS)) begin
          ping_phase_next  = urpd_pkg::PH_WAIT_IDLE;
          phase_ticks_next = '0;
          echo_width_next  = '0;
        end else begin
          phase_ticks_next = ticks_inc[15:0];
        end
      end
      urpd_pkg::PH_WAIT_IDLE, urpd_pkg::PH_WAIT_RISE, urpd_pkg::PH_MEASURE: begin
        if (ping_phase == urpd_pkg::PH_WAIT_IDLE) begin
          if (!echo) ping_phase_next = urpd_pkg::PH_WAIT_RISE;
        end else if (ping_phase == urpd_pkg::PH_WAIT_RISE) begin
          if (echo) begin
            ping_phase_next = urpd_pkg::PH_MEASURE;
            echo_width_next = 16'd1;
          end
        end else if (echo && echo_width != 16'hFFFF) begin
          echo_width_next = echo_width + 16'd1;
        end
        if (done) begin
          ping_phase_next  = urpd_pkg::PH_GAP;
          phase_ticks_next = '0;
        end else begin
          phase_ticks_next = ticks_inc[15:0];
        end
      end
      urpd_pkg::PH_GAP: begin
        if (ticks_inc >= {1'b0, ping_gap}) begin
          active_zone_next = !active_zone;
          ping_phase_next  = urpd_pkg::PH_TRIG_LOW;
          phase_ticks_next = '0;
        end else begin
          phase_ticks_next = ticks_inc[15:0];
        end
      end
      default: begin
        ping_phase_next  = urpd_pkg::PH_TRIG_LOW;
        phase_ticks_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_zone <= 1'b0;
      ping_phase  <= urpd_pkg::PH_TRIG_LOW;
      phase_ticks <= '0;
      echo_width  <= '0;
      pwm_count   <= '0;
    end else if (accept) begin
      active_zone <= active_zone_next;
      ping_phase  <= ping_phase_next;
      phase_ticks <= phase_ticks_next;
      echo_width  <= echo_width_next;
      pwm_count   <= pwm_count_next;
    end
  end

  // ---------------- stage 1 register and curve ROM ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_trig_a   <= trig && !active_zone;
      s1_trig_b   <= trig && active_zone;
      s1_done     <= done;
      s1_zone     <= active_zone;
      s1_mm       <= mm_val;
      s1_lut_zero <= lut_zero;
      s1_pwm_pos  <= pwm_count;
      s1_period   <= pwm_period;
      rom_q       <= CURVE[rom_addr];
    end
  end

  // ---------------- stage 2: duty, PWM ----------------
  always_comb begin
    duty    = s1_lut_zero ? 8'd0 : rom_q;
    thr_a   = 24'(zone_duty[0]) * 24'(s1_period);
    thr_b   = 24'(zone_duty[1]) * 24'(s1_period);
    pwm_pos = {s1_pwm_pos, 8'd0};
  end

  // duty written as the item leaves stage 1, so the next tick sees it
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_duty[0] <= '0;
      zone_duty[1] <= '0;
    end else if (adv && s1_valid && s1_done) begin
      zone_duty[s1_zone] <= duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      trig_a             <= s1_trig_a;
      trig_b             <= s1_trig_b;
      motor_a            <= pwm_pos < thr_a;
      motor_b            <= pwm_pos < thr_b;
      report_valid       <= s1_done;
      report_zone        <= s1_done && s1_zone;
      report_distance_mm <= s1_done ? s1_mm : '0;
      report_duty        <= s1_done ? duty : '0;
    end
  end

  // ---------------- assertions ----------------
  a_no_trig_on_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_valid |-> !trig_a && !trig_b)
    else $error("report on a trigger tick");

  a_one_trigger: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(trig_a && trig_b))
    else $error("both triggers high");

  a_duty_stored: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_valid |-> zone_duty[report_zone] == report_duty)
    else $error("reported duty not stored for its zone");

  a_trig_count: assert property (@(posedge clk) disable iff (rst)
    ping_phase == urpd_pkg::PH_TRIG_HIGH |-> phase_ticks < 16'(urpd_pkg::TRIG_HIGH_TICKS))
    else $error("trigger pulse overran");

endmodule

[dv/ultrasonic_range_to_pwm_duty_top_tb.sv]
// ----------------------------------------------------------------------------
// ultrasonic_range_to_pwm_duty_top_tb
// Drives one echo tick item per handshake into the two-zone ranger and checks
// every output tick against an in-bench model of the ping sequencer, distance
// math, ramp curve and PWM (typed rows of the short directed table that goes
// first against their own values); then phases of echo pulses shaped from the
// model's ping state under several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module ultrasonic_range_to_pwm_duty_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic               trig_a;
    logic               trig_b;
    logic               motor_a;
    logic               motor_b;
    logic               rpt_valid;
    logic               rpt_zone;
    logic signed [13:0] range_mm;
    logic        [7:0]  duty;
  } tick_out_t;

  typedef struct {
    logic      ea;
    logic      eb;
    int        reps;
    bit        typed;
    tick_out_t want;
  } dir_row_t;

  typedef enum int {
    PLAN_PULSE,
    PLAN_SILENT,
    PLAN_STUCK,
    PLAN_NOISE
  } echo_plan_t;

  localparam logic [1:0]  REG_SPARE      = 2'd3;  // decodes to nothing
  localparam int unsigned SOUND_NUM      = 343;
  localparam int unsigned SOUND_DEN      = 2000;
  localparam int unsigned WIDTH_SAT      = 32'hFFFF;
  localparam u64_t        Q24_ONE        = 64'd1 << 24;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          NUM_PHASES     = 8;
  localparam int          PHASE_ITEMS    = 71;
  localparam tick_out_t   NO_OUT         = '0;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               echo_a = 1'b0;
  logic               echo_b = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               trig_a;
  logic               trig_b;
  logic               motor_a;
  logic               motor_b;
  logic               report_valid;
  logic               report_zone;
  logic signed [13:0] report_distance_mm;
  logic        [7:0]  report_duty;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [1:0]  cfg_index = 2'd0;
  logic        [15:0] cfg_data = 16'd0;

  ultrasonic_range_to_pwm_duty_top dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .echo_a             (echo_a),
    .echo_b             (echo_b),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .trig_a             (trig_a),
    .trig_b             (trig_b),
    .motor_a            (motor_a),
    .motor_b            (motor_b),
    .report_valid       (report_valid),
    .report_zone        (report_zone),
    .report_distance_mm (report_distance_mm),
    .report_duty        (report_duty),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------- ranger model state ----------------
  logic [7:0]       duty_rom [urpd_pkg::CURVE_TABLE_DEPTH];
  int unsigned      tmo_reg    = 32'(urpd_pkg::ECHO_TIMEOUT_RST);
  int unsigned      gap_reg    = 32'(urpd_pkg::PING_GAP_RST);
  int unsigned      period_reg = 32'(urpd_pkg::PWM_PERIOD_RST);
  logic             cur_zone   = 1'b0;
  urpd_pkg::phase_t ping_ph    = urpd_pkg::PH_TRIG_LOW;
  int unsigned      ph_cnt     = 0;
  int unsigned      echo_len   = 0;
  int unsigned      duty_of [2] = '{0, 0};
  int unsigned      pwm_pos    = 0;

  tick_out_t pending_ticks [$];
  int        errors = 0;
  int        items_seen;
  int        snd_idle_pct = 0;
  int        rcv_stall_pct = 0;
  logic      hold_req = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_cnt = 0;
  int        idle_cycles = 0;

  // echo shaping for the zone being pinged
  bit          need_plan = 1'b1;
  echo_plan_t  plan_kind = PLAN_PULSE;
  int unsigned plan_t0, plan_pre, plan_lo, plan_w;
  int unsigned force_width = 0;

  // Taylor series on x/16 in Q24, then squared four times
  function automatic u64_t fx_exp(input u64_t x);
    u64_t r;
    u64_t term;
    u64_t acc;
    r    = x >> 4;
    term = Q24_ONE;
    acc  = Q24_ONE;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * r) >> 24) / u64_t'(k);
      acc  = acc + term;
    end
    for (int i = 0; i < 4; i++) begin
      acc = (acc * acc) >> 24;
    end
    return acc;
  endfunction

  function automatic logic [7:0] curve_point(input int mm);
    u64_t x;
    u64_t num;
    u64_t den;
    u64_t lvl;
    if (mm < 0 || mm > urpd_pkg::FAR_OFF_MM) begin
      return 8'd0;
    end
    if (mm <= urpd_pkg::NEAR_FULL_MM) begin
      return 8'd255;
    end
    x   = (u64_t'(urpd_pkg::FAR_OFF_MM - mm) << 26) /
          u64_t'(urpd_pkg::FAR_OFF_MM - urpd_pkg::NEAR_FULL_MM);
    num = fx_exp(x) - Q24_ONE;
    den = fx_exp(u64_t'(4) << 24) - Q24_ONE;
    lvl = u64_t'(urpd_pkg::DUTY_FLOOR) + (num * u64_t'(255 - urpd_pkg::DUTY_FLOOR)) / den;
    return (lvl > 64'd255) ? 8'd255 : lvl[7:0];
  endfunction

  function automatic tick_out_t advance_ranger(input logic ea, input logic eb);
    tick_out_t   o;
    logic        echo;
    bit          done;
    int          mm;
    int unsigned d;
    o    = '0;
    done = 1'b0;
    mm   = 0;
    echo = cur_zone ? eb : ea;
    o.trig_a  = (ping_ph == urpd_pkg::PH_TRIG_HIGH) && !cur_zone;
    o.trig_b  = (ping_ph == urpd_pkg::PH_TRIG_HIGH) && cur_zone;
    o.motor_a = (pwm_pos * 256) < (duty_of[0] * period_reg);
    o.motor_b = (pwm_pos * 256) < (duty_of[1] * period_reg);
    pwm_pos = (pwm_pos + 1 >= period_reg) ? 0 : pwm_pos + 1;

    case (ping_ph)
      urpd_pkg::PH_TRIG_LOW: begin
        ph_cnt++;
        if (ph_cnt >= 32'(urpd_pkg::TRIG_LOW_TICKS)) begin
          ping_ph = urpd_pkg::PH_TRIG_HIGH;
          ph_cnt  = 0;
        end
      end
      urpd_pkg::PH_TRIG_HIGH: begin
        ph_cnt++;
        if (ph_cnt >= 32'(urpd_pkg::TRIG_HIGH_TICKS)) begin
          ping_ph  = urpd_pkg::PH_WAIT_IDLE;
          ph_cnt   = 0;
          echo_len = 0;
        end
      end
      urpd_pkg::PH_WAIT_IDLE, urpd_pkg::PH_WAIT_RISE, urpd_pkg::PH_MEASURE: begin
        if (ping_ph == urpd_pkg::PH_WAIT_IDLE) begin
          if (!echo) ping_ph = urpd_pkg::PH_WAIT_RISE;
        end else if (ping_ph == urpd_pkg::PH_WAIT_RISE) begin
          if (echo) begin
            ping_ph  = urpd_pkg::PH_MEASURE;
            echo_len = 1;
          end
        end else if (echo) begin
          if (echo_len < WIDTH_SAT) echo_len++;
        end else begin
          d    = (echo_len * SOUND_NUM) / SOUND_DEN;
          mm   = (d > 32'(urpd_pkg::DIST_MAX)) ? int'(urpd_pkg::DIST_MAX) : int'(d);
          done = 1'b1;
        end
        // timeout runs from the end of the trigger, not from the rise
        if (!done) begin
          ph_cnt++;
          if (ph_cnt >= tmo_reg) begin
            mm   = -1;
            done = 1'b1;
          end
        end
        if (done) begin
          if (mm < 0 || mm > urpd_pkg::FAR_OFF_MM) begin
            o.duty = 8'd0;
          end else begin
            o.duty = duty_rom[(mm < urpd_pkg::CURVE_TABLE_DEPTH) ? mm :
                              urpd_pkg::CURVE_TABLE_DEPTH - 1];
          end
          duty_of[cur_zone] = 32'(o.duty);
          o.rpt_valid = 1'b1;
          o.rpt_zone  = cur_zone;
          o.range_mm  = mm[13:0];
          ping_ph     = urpd_pkg::PH_GAP;
          ph_cnt      = 0;
        end
      end
      urpd_pkg::PH_GAP: begin
        ph_cnt++;
        if (ph_cnt >= gap_reg) begin
          cur_zone = ~cur_zone;
          ping_ph  = urpd_pkg::PH_TRIG_LOW;
          ph_cnt   = 0;
        end
      end
      default: begin
        ping_ph = urpd_pkg::PH_TRIG_LOW;
        ph_cnt  = 0;
      end
    endcase
    return o;
  endfunction

  // Echo levels for the next item: bit 0 zone A, bit 1 zone B. Only the zone
  // being timed follows a plan; everything else is random.
  function automatic logic [1:0] next_echo();
    logic [1:0]  e;
    logic        live;
    int unsigned t;
    int unsigned r;
    e = 2'($urandom_range(0, 3));
    if (ping_ph inside {urpd_pkg::PH_WAIT_IDLE, urpd_pkg::PH_WAIT_RISE,
                        urpd_pkg::PH_MEASURE}) begin
      if (need_plan) begin
        need_plan = 1'b0;
        plan_t0   = ph_cnt;
        plan_pre  = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 6) : 0;
        plan_lo   = $urandom_range(1, 8);
        r = $urandom_range(0, 99);
        if (force_width != 0) plan_kind = PLAN_PULSE;
        else if (r < 70) plan_kind = PLAN_PULSE;
        else if (r < 80) plan_kind = PLAN_SILENT;
        else if (r < 85) plan_kind = PLAN_STUCK;
        else plan_kind = PLAN_NOISE;
        r = $urandom_range(0, 99);
        if (force_width != 0) plan_w = force_width;
        else if (r < 55) plan_w = $urandom_range(1, 25);
        else if (r < 85) plan_w = $urandom_range(25, 60);
        else plan_w = $urandom_range(120, 160);
      end
      t = ph_cnt - plan_t0;
      case (plan_kind)
        PLAN_PULSE: live = (t < plan_pre) ||
                           (t >= plan_pre + plan_lo && t < plan_pre + plan_lo + plan_w);
        PLAN_SILENT: live = 1'b0;
        PLAN_STUCK:  live = 1'b1;
        default:     live = e[cur_zone];
      endcase
      e[cur_zone] = live;
    end else begin
      need_plan = 1'b1;
    end
    return e;
  endfunction

  // ---------------- sender side ----------------
  task automatic offer_tick(input logic ea, input logic eb, input bit typed,
                            input tick_out_t want);
    tick_out_t pred;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    echo_a   <= ea;
    echo_b   <= eb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = advance_ranger(ea, eb);
    pending_ticks.push_back(typed ? want : pred);
    items_seen++;
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      urpd_pkg::REG_ECHO_TIMEOUT: tmo_reg    = 32'(val[15:0]);
      urpd_pkg::REG_PING_GAP:     gap_reg    = 32'(val[15:0]);
      urpd_pkg::REG_PWM_PERIOD:   period_reg = 32'(val[15:0]);
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_ticks.size() != 0);
  endtask

  // A pings with a one-tick echo (0 mm, full duty), B never sees its echo fall
  dir_row_t dir_rows [10] = '{
    '{1'b0, 1'b0, 2,  1'b1, NO_OUT},
    '{1'b1, 1'b1, 10, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 14'sd0, 8'd0}},
    '{1'b0, 1'b1, 1,  1'b1, NO_OUT},
    '{1'b1, 1'b0, 1,  1'b1, NO_OUT},
    '{1'b0, 1'b1, 1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 14'sd0, 8'd255}},
    '{1'b0, 1'b0, 1,  1'b0, NO_OUT},   // zero gap acts as one tick
    '{1'b1, 1'b1, 2,  1'b0, NO_OUT},
    '{1'b0, 1'b0, 10, 1'b0, NO_OUT},
    '{1'b0, 1'b1, 3,  1'b0, NO_OUT},
    '{1'b0, 1'b1, 1,  1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, -14'sd1, 8'd0}}
  };

  initial begin
    logic [1:0]  e;
    int unsigned tmo, gap, per;
    for (int i = 0; i < urpd_pkg::CURVE_TABLE_DEPTH; i++) duty_rom[i] = curve_point(i);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_reg(urpd_pkg::REG_ECHO_TIMEOUT, 4);
    write_reg(urpd_pkg::REG_PING_GAP, 0);
    write_reg(urpd_pkg::REG_PWM_PERIOD, 256);
    cfg_valid <= 1'b0;
    foreach (dir_rows[i]) begin
      for (int n = 0; n < dir_rows[i].reps; n++) begin
        offer_tick(dir_rows[i].ea, dir_rows[i].eb, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      force_width = 0;
      tmo = $urandom_range(20, 300);
      gap = $urandom_range(1, 12);
      per = $urandom_range(256, 4000);
      case (p)
        0: begin
          tmo = 300;
          per = 256;
          snd_idle_pct = 0;
          rcv_stall_pct <= 0;
        end
        1: begin
          snd_idle_pct = 46;
          rcv_stall_pct <= 0;
        end
        2: begin
          snd_idle_pct = 0;
          rcv_stall_pct <= 46;
          hold_req <= 1'b1;  // long receiver hold-off while items keep coming
        end
        3: begin
          per = $urandom_range(1, 255);
          snd_idle_pct = 34;
          rcv_stall_pct <= 34;
        end
        4: begin
          // zero timeout, zero gap, zero period
          tmo = 0;
          gap = 0;
          per = 0;
          snd_idle_pct = 0;
          rcv_stall_pct <= 0;
          write_reg(REG_SPARE, $urandom_range(0, 65535));
        end
        5: begin
          // full-scale registers with a fixed echo width
          tmo = 65535;
          gap = 65535;
          per = 65535;
          force_width = 45;
        end
        6: begin
          tmo = 1;
          gap = 1;
          per = 256;
          snd_idle_pct = 34;
          rcv_stall_pct <= 34;
        end
        default: begin
          tmo = $urandom_range(30, 400);
          gap = $urandom_range(1, 12);
          per = 5000;
          snd_idle_pct = 46;
          rcv_stall_pct <= 0;
        end
      endcase
      write_reg(urpd_pkg::REG_ECHO_TIMEOUT, tmo);
      write_reg(urpd_pkg::REG_PING_GAP, gap);
      write_reg(urpd_pkg::REG_PWM_PERIOD, per);
      cfg_valid <= 1'b0;
      need_plan  = 1'b1;
      items_seen = 0;
      while (items_seen < PHASE_ITEMS) begin
        e = next_echo();
        offer_tick(e[0], e[1], 1'b0, NO_OUT);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ultrasonic_range_to_pwm_duty_top_tb: clean");
    end else begin
      $display("ultrasonic_range_to_pwm_duty_top_tb: errors");
    end
    $finish;
  end

  // ---------------- receiver side ----------------
  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      errors++;
      if (errors <= 40) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    tick_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_ticks.size() == 0) begin
        errors++;
        if (errors <= 40) $error("output item with nothing expected");
      end else begin
        want = pending_ticks.pop_front();
        check_field("trig_a", want.trig_a, trig_a);
        check_field("trig_b", want.trig_b, trig_b);
        check_field("motor_a", want.motor_a, motor_a);
        check_field("motor_b", want.motor_b, motor_b);
        check_field("report_valid", want.rpt_valid, report_valid);
        check_field("report_zone", want.rpt_zone, report_zone);
        check_field("report_distance_mm", $signed(want.range_mm), report_distance_mm);
        check_field("report_duty", want.duty, report_duty);
      end
    end
    if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ultrasonic_range_to_pwm_duty_top_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
